FILE: hdl/lop_pkg.sv
// ----------------------------------------------------------------------------
// lop_pkg
// Shared sizes, word tables and letter-code helper for the ordinal parser.
// ----------------------------------------------------------------------------
`default_nettype none

package lop_pkg;

  // Longest word (letters and dashes) that can still match.
  localparam int WORD_BUFFER = 16;
  // Width of character positions and of the reported offset.
  localparam int OFFSET_BITS = 16;

  localparam int ValueW    = 31;
  localparam int WordLenW  = $clog2(WORD_BUFFER + 2);
  localparam int WordLenMax = WORD_BUFFER + 1;

  localparam int NumWhole = 27;  // ones, teens, tens ordinals
  localparam int NumOnes  = 9;   // the first nine whole entries
  localparam int NumCard  = 8;   // tens cardinals

  localparam logic [4:0] DashCode = 5'd27;

  // Word text, right-justified; first letter sits in the highest used byte.
  localparam logic [87:0] WHOLE_TXT [NumWhole] = '{
    "first", "second", "third", "fourth", "fifth",
    "sixth", "seventh", "eighth", "ninth",
    "tenth", "eleventh", "twelfth", "thirteenth", "fourteenth",
    "fifteenth", "sixteenth", "seventeenth", "eighteenth", "nineteenth",
    "twentieth", "thirtieth", "fortieth", "fiftieth",
    "sixtieth", "seventieth", "eightieth", "ninetieth"
  };
  localparam logic [3:0] WHOLE_LEN [NumWhole] = '{
    4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd5, 4'd7, 4'd6, 4'd5,
    4'd5, 4'd8, 4'd7, 4'd10, 4'd10, 4'd9, 4'd9, 4'd11, 4'd10, 4'd10,
    4'd9, 4'd9, 4'd8, 4'd8, 4'd8, 4'd10, 4'd9, 4'd9
  };
  localparam logic [6:0] WHOLE_VAL [NumWhole] = '{
    7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9,
    7'd10, 7'd11, 7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17, 7'd18, 7'd19,
    7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90
  };

  localparam logic [87:0] CARD_TXT [NumCard] = '{
    "twenty", "thirty", "forty", "fifty", "sixty", "seventy", "eighty", "ninety"
  };
  localparam logic [3:0] CARD_LEN [NumCard] = '{
    4'd6, 4'd6, 4'd5, 4'd5, 4'd5, 4'd7, 4'd6, 4'd6
  };
  localparam logic [6:0] CARD_VAL [NumCard] = '{
    7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90
  };

  // Letter code (a..z = 1..26) of a table word at index k; 0 past its end.
  function automatic logic [4:0] txt_code(input logic [87:0] txt,
                                          input logic [3:0] len,
                                          input logic [WordLenW-1:0] k);
    logic [3:0] idx;
    logic [7:0] ch;
    idx = 4'(len - 4'(k) - 4'd1);
    ch  = txt[{idx, 3'b000} +: 8];
    if (WordLenW'(len) > k) begin
      return 5'(ch - 8'd96);
    end
    return 5'd0;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/leading_ordinal_parser_top.sv
// ----------------------------------------------------------------------------
// leading_ordinal_parser_top
// Recognizes a leading numeric or spelled-out ordinal in a character stream.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, every cycle, while the result slot is
//   free or being drained; the per-character state update is a single step.
// Result: the result shows on out_valid_o in the cycle after the NUL transfer.
// Reset: rst_ni clears the parse state to start of string and empties the
//   result register; no clearing pass, the block is ready at once.
`default_nettype none

module leading_ordinal_parser_top (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [7:0]                      text_char_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [lop_pkg::ValueW-1:0]      ordinal_value_o,
  output logic [lop_pkg::OFFSET_BITS-1:0] rest_offset_o
);
  import lop_pkg::*;

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_DIGITS = 3'd1;
  localparam logic [2:0] PH_SUFFIX = 3'd2;
  localparam logic [2:0] PH_WORD   = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_NONE   = 3'd6;

  localparam logic [OFFSET_BITS-1:0] OffCap   = '1;
  localparam logic [ValueW-1:0]      ValueCap = '1;

  // Parse state
  logic [2:0]             phase_q, phase_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [ValueW-1:0]      accum_q, accum_d;
  logic [7:0]             suffix_q, suffix_d;
  logic [WordLenW-1:0]    wlen_q, wlen_d;
  logic                   dash_q, dash_d;
  logic [WordLenW-1:0]    rlen_q, rlen_d;     // letters after the first dash
  logic [6:0]             tens_q, tens_d;     // cardinal left of the dash
  logic [NumWhole-1:0]    whole_q, whole_d;   // whole-word candidates alive
  logic [NumCard-1:0]     card_q, card_d;     // tens-cardinal candidates alive
  logic [NumOnes-1:0]     right_q, right_d;   // ones candidates after dash
  logic [ValueW-1:0]      fval_q, fval_d;
  logic [OFFSET_BITS-1:0] frest_q, frest_d;

  // Result register
  logic                   out_valid_q;
  logic [ValueW-1:0]      out_val_q, res_val;
  logic [OFFSET_BITS-1:0] out_rest_q, res_rest;

  logic in_xfer, is_end;
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign is_end     = (text_char_i == 8'd0);

  // Character classes
  logic       is_dig, is_upper, is_alpha, is_dash, is_blank;
  logic [7:0] lc;
  logic [4:0] code;
  assign is_dig   = (text_char_i >= "0") && (text_char_i <= "9");
  assign is_upper = (text_char_i >= "A") && (text_char_i <= "Z");
  assign is_alpha = is_upper || ((text_char_i >= "a") && (text_char_i <= "z"));
  assign is_dash  = (text_char_i == "-");
  assign is_blank = (text_char_i == " ") || (text_char_i == 8'h09);
  assign lc       = is_upper ? text_char_i + 8'd32 : text_char_i;
  assign code     = is_dash ? DashCode : 5'(lc - 8'd96);

  logic [OFFSET_BITS-1:0] pos_next;
  assign pos_next = (pos_q == OffCap) ? pos_q : pos_q + OFFSET_BITS'(1);

  // Digit accumulate with saturation: acc * 10 + digit
  logic [ValueW+3:0] acc_wide;
  assign acc_wide = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0}
                  + (ValueW+4)'(text_char_i - "0");

  // Word push: candidate letters are checked as they arrive
  logic                base_start;
  logic [WordLenW-1:0] base_len;
  logic [NumWhole-1:0] base_whole, whole_push;
  logic [NumCard-1:0]  base_card, card_push, card_hit;
  logic [NumOnes-1:0]  right_push;
  logic                base_dash, first_dash;
  logic [6:0]          tens_hit;

  assign base_start = (phase_q == PH_START);
  assign base_len   = base_start ? '0 : wlen_q;
  assign base_whole = base_start ? '1 : whole_q;
  assign base_card  = base_start ? '1 : card_q;
  assign base_dash  = base_start ? 1'b0 : dash_q;
  assign first_dash = is_dash && !base_dash && (base_len < WordLenW'(WORD_BUFFER));

  always_comb begin
    tens_hit = '0;
    for (int i = 0; i < NumWhole; i++) begin
      whole_push[i] = base_whole[i]
                    && (txt_code(WHOLE_TXT[i], WHOLE_LEN[i], base_len) == code);
    end
    for (int i = 0; i < NumCard; i++) begin
      card_push[i] = base_card[i]
                   && (txt_code(CARD_TXT[i], CARD_LEN[i], base_len) == code);
      card_hit[i]  = base_card[i] && (WordLenW'(CARD_LEN[i]) == base_len);
      tens_hit     = tens_hit | (card_hit[i] ? CARD_VAL[i] : 7'd0);
    end
    for (int i = 0; i < NumOnes; i++) begin
      right_push[i] = right_q[i]
                    && (txt_code(WHOLE_TXT[i], WHOLE_LEN[i], rlen_q) == code);
    end
  end

  // End-of-word evaluation from the stored candidates
  logic [6:0]  whole_val, ones_val, word_val;
  always_comb begin
    whole_val = '0;
    ones_val  = '0;
    for (int i = 0; i < NumWhole; i++) begin
      if (whole_q[i] && (WordLenW'(WHOLE_LEN[i]) == wlen_q)) begin
        whole_val = whole_val | WHOLE_VAL[i];
      end
    end
    for (int i = 0; i < NumOnes; i++) begin
      if (right_q[i] && (WordLenW'(WHOLE_LEN[i]) == rlen_q)) begin
        ones_val = ones_val | WHOLE_VAL[i];
      end
    end
    if (wlen_q == '0 || wlen_q > WordLenW'(WORD_BUFFER)) begin
      word_val = '0;
    end else if (whole_val != '0) begin
      word_val = whole_val;
    end else if (dash_q && tens_q != '0 && ones_val != '0) begin
      word_val = tens_q + ones_val;
    end else begin
      word_val = '0;
    end
  end

  logic suffix_ok;
  assign suffix_ok = (suffix_q == "s" && lc == "t") || (suffix_q == "n" && lc == "d")
                  || (suffix_q == "r" && lc == "d") || (suffix_q == "t" && lc == "h");

  // Next state
  always_comb begin
    phase_d  = phase_q;
    accum_d  = accum_q;
    suffix_d = suffix_q;
    wlen_d   = wlen_q;
    dash_d   = dash_q;
    rlen_d   = rlen_q;
    tens_d   = tens_q;
    whole_d  = whole_q;
    card_d   = card_q;
    right_d  = right_q;
    fval_d   = fval_q;
    frest_d  = frest_q;
    res_val  = '0;
    res_rest = '0;

    unique case (phase_q) inside
      PH_START, PH_WORD: begin
        if (is_alpha || is_dash) begin
          phase_d = PH_WORD;
          whole_d = whole_push;
          card_d  = card_push;
          dash_d  = base_dash;
          wlen_d  = (base_len == WordLenW'(WordLenMax)) ? base_len
                                                         : base_len + WordLenW'(1);
          if (first_dash) begin
            dash_d  = 1'b1;
            tens_d  = tens_hit;
            rlen_d  = '0;
            right_d = '1;
          end else if (base_dash) begin
            right_d = right_push;
            rlen_d  = (rlen_q == WordLenW'(WordLenMax)) ? rlen_q : rlen_q + WordLenW'(1);
          end
        end else if (phase_q == PH_START) begin
          if (is_dig) begin
            accum_d = ValueW'(text_char_i - "0");
            phase_d = PH_DIGITS;
          end else begin
            phase_d = PH_NONE;
          end
        end else if (word_val != '0) begin
          fval_d  = ValueW'(word_val);
          frest_d = is_blank ? pos_next : pos_q;
          phase_d = is_blank ? PH_SKIP : PH_DONE;
        end else begin
          phase_d = PH_NONE;
        end
      end
      PH_DIGITS: begin
        if (is_dig) begin
          accum_d = (acc_wide > (ValueW+4)'(ValueCap)) ? ValueCap : ValueW'(acc_wide);
        end else if (lc == "s" || lc == "n" || lc == "r" || lc == "t") begin
          suffix_d = lc;
          phase_d  = PH_SUFFIX;
        end else begin
          phase_d = PH_NONE;
        end
      end
      PH_SUFFIX: begin
        if (suffix_ok && accum_q != '0) begin
          fval_d  = accum_q;
          frest_d = pos_next;
          phase_d = PH_SKIP;
        end else begin
          phase_d = PH_NONE;
        end
      end
      PH_SKIP: begin
        if (is_blank) begin
          frest_d = pos_next;
        end else begin
          phase_d = PH_DONE;
        end
      end
      default: ;
    endcase

    pos_d = pos_next;

    // NUL closes the string: report and start afresh
    if (is_end) begin
      if (phase_d == PH_DONE) begin
        res_val  = fval_d;
        res_rest = frest_d;
      end
      phase_d  = PH_START;
      pos_d    = '0;
      accum_d  = '0;
      suffix_d = '0;
      wlen_d   = '0;
      dash_d   = 1'b0;
      rlen_d   = '0;
      tens_d   = '0;
      fval_d   = '0;
      frest_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      pos_q    <= '0;
      accum_q  <= '0;
      suffix_q <= '0;
      wlen_q   <= '0;
      dash_q   <= 1'b0;
      rlen_q   <= '0;
      tens_q   <= '0;
      whole_q  <= '0;
      card_q   <= '0;
      right_q  <= '0;
      fval_q   <= '0;
      frest_q  <= '0;
    end else if (in_xfer) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      accum_q  <= accum_d;
      suffix_q <= suffix_d;
      wlen_q   <= wlen_d;
      dash_q   <= dash_d;
      rlen_q   <= rlen_d;
      tens_q   <= tens_d;
      whole_q  <= whole_d;
      card_q   <= card_d;
      right_q  <= right_d;
      fval_q   <= fval_d;
      frest_q  <= frest_d;
    end
  end

  // Result slot: refilled in the same cycle it drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && is_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && is_end) begin
      out_val_q  <= res_val;
      out_rest_q <= res_rest;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ordinal_value_o = out_val_q;
  assign rest_offset_o   = out_rest_q;

endmodule

`default_nettype wire

FILE: hdl/lop_checker.sv
// ----------------------------------------------------------------------------
// lop_checker
// Port-level checks for the ordinal parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lop_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             in_valid_i,
  input wire                             in_stall_o,
  input wire [7:0]                       text_char_i,
  input wire                             out_valid_o,
  input wire                             out_stall_i,
  input wire [lop_pkg::ValueW-1:0]       ordinal_value_o,
  input wire [lop_pkg::OFFSET_BITS-1:0]  rest_offset_o
);
  import lop_pkg::*;

  // Held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(ordinal_value_o) && $stable(rest_offset_o))
    else $error("result changed while stalled");

  // Input is only held off by a full, stalled result slot
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

  // No ordinal means no offset
  a_zero_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ordinal_value_o == '0) |-> (rest_offset_o == '0))
    else $error("offset reported without an ordinal");

  // A fresh result follows a NUL transfer
  a_fresh_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !($past(out_valid_o) && $past(out_stall_i)) |->
      $past(in_valid_i) && !$past(in_stall_o) && ($past(text_char_i) == 8'd0))
    else $error("result without a string end");

endmodule

bind leading_ordinal_parser_top lop_checker u_lop_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .text_char_i     (text_char_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .ordinal_value_o (ordinal_value_o),
  .rest_offset_o   (rest_offset_o)
);

`default_nettype wire
